@@ rtl/rbsi_pkg.sv @@
package rbsi_pkg;

   // value format
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int AXES        = 3;
   localparam int LANES       = 2 * AXES;

   // derived widths
   localparam int SUM_WIDTH      = 2 * VALUE_WIDTH;
   localparam int LEN_WIDTH      = VALUE_WIDTH;
   localparam int COMP_WIDTH     = FRAC_BITS + 1;
   localparam int T_WIDTH        = VALUE_WIDTH + 2;
   localparam int TLEN_WIDTH     = VALUE_WIDTH - 1;
   localparam int PROD_WIDTH     = TLEN_WIDTH + COMP_WIDTH;
   localparam int DIR_REM_WIDTH  = VALUE_WIDTH + FRAC_BITS + 1;
   localparam int SLAB_REM_WIDTH = VALUE_WIDTH + FRAC_BITS;

   // pipeline depths of the iterative units
   localparam int SQRT_STAGES = SUM_WIDTH / 2;
   localparam int DIR_STAGES  = COMP_WIDTH;
   localparam int SLAB_STAGES = VALUE_WIDTH;

   localparam logic [1:0] AXIS_INSIDE = 2'd3;

   // register map
   typedef enum logic [2:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   // per-ray data that travels alongside the arithmetic units
   typedef struct packed {
      logic [AXES-1:0][VALUE_WIDTH-1:0] org;
      logic [AXES-1:0][VALUE_WIDTH-1:0] dmag;
      logic [AXES-1:0]                  dneg;
      logic [TLEN_WIDTH-1:0]            tmax;
      logic [AXES-1:0][COMP_WIDTH-1:0]  comp;
      logic [AXES-1:0]                  par;
      logic                             par_fail;
   } ray_type;

   // one slab division lane
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] num;
      logic [COMP_WIDTH-1:0]  den;
      logic                   sat;
      logic                   neg;
   } slab_lane_type;

endpackage

@@ rtl/rbsi_sqrt.sv @@
module rbsi_sqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [rbsi_pkg::SUM_WIDTH-1:0]       in_sum,
   input  rbsi_pkg::ray_type                    in_ray,
   output logic                                 out_valid,
   output logic [rbsi_pkg::LEN_WIDTH-1:0]       out_root,
   output rbsi_pkg::ray_type                    out_ray
);

   localparam int N = rbsi_pkg::SQRT_STAGES;
   localparam int W = rbsi_pkg::SUM_WIDTH;

   logic [N-1:0]      valid_ff;
   logic [W-1:0]      rad_ff  [N];
   logic [W-1:0]      root_ff [N];
   rbsi_pkg::ray_type ray_ff  [N];

   // one result bit per stage
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic              v_prev;
      logic [W-1:0]      rad_prev, root_prev, rad_in, root_in;
      logic [W:0]        trial;
      rbsi_pkg::ray_type ray_prev;
      localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * s);

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rad_prev  = in_sum;
         assign root_prev = '0;
         assign ray_prev  = in_ray;
      end else begin : g_next
         assign v_prev    = valid_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign ray_prev  = ray_ff[s-1];
      end

      always_comb begin
         trial = {1'b0, root_prev} + {1'b0, BIT};
         if ({1'b0, rad_prev} >= trial) begin
            rad_in  = rad_prev - trial[W-1:0];
            root_in = (root_prev >> 1) + BIT;
         end else begin
            rad_in  = rad_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_in;
            root_ff[s] <= root_in;
            ray_ff[s]  <= ray_prev;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1][rbsi_pkg::LEN_WIDTH-1:0];
   assign out_ray   = ray_ff[N-1];

endmodule

@@ rtl/rbsi_dir_div.sv @@
module rbsi_dir_div (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  en,
   input  logic                                                  in_valid,
   input  logic [rbsi_pkg::LEN_WIDTH-1:0]                        in_len,
   input  rbsi_pkg::ray_type                                     in_ray,
   output logic                                                  out_valid,
   output logic [rbsi_pkg::AXES-1:0][rbsi_pkg::COMP_WIDTH-1:0]   out_comp,
   output rbsi_pkg::ray_type                                     out_ray
);

   localparam int N  = rbsi_pkg::DIR_STAGES;
   localparam int RW = rbsi_pkg::DIR_REM_WIDTH;
   localparam int A  = rbsi_pkg::AXES;
   localparam int QW = rbsi_pkg::COMP_WIDTH;
   localparam int LW = rbsi_pkg::LEN_WIDTH;

   logic [N-1:0]          valid_ff;
   logic [A-1:0][RW-1:0]  rem_ff  [N];
   logic [A-1:0][QW-1:0]  quot_ff [N];
   logic [LW-1:0]         den_ff  [N];
   rbsi_pkg::ray_type     ray_ff  [N];

   // one quotient bit per stage, three lanes side by side
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                 v_prev;
      logic [A-1:0][RW-1:0] rem_prev, rem_in;
      logic [A-1:0][QW-1:0] quot_prev, quot_in;
      logic [LW-1:0]        den_prev;
      logic [RW-1:0]        trial;
      rbsi_pkg::ray_type    ray_prev;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign den_prev  = in_len;
         assign ray_prev  = in_ray;
         assign quot_prev = '0;
         for (genvar a = 0; a < A; a++) begin : g_init
            assign rem_prev[a] = RW'({in_ray.dmag[a], {rbsi_pkg::FRAC_BITS{1'b0}}});
         end
      end else begin : g_next
         assign v_prev    = valid_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign ray_prev  = ray_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
      end

      always_comb begin
         trial   = RW'(den_prev) << (N - 1 - s);
         rem_in  = rem_prev;
         quot_in = quot_prev;
         for (int a = 0; a < A; a++) begin
            if (rem_prev[a] >= trial) begin
               rem_in[a]             = rem_prev[a] - trial;
               quot_in[a][N - 1 - s] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= quot_in;
            den_ff[s]  <= den_prev;
            ray_ff[s]  <= ray_prev;
         end
      end
   end

   // zero length: every component is zero
   assign out_valid = valid_ff[N-1];
   assign out_comp  = (den_ff[N-1] == '0) ? '0 : quot_ff[N-1];
   assign out_ray   = ray_ff[N-1];

endmodule

@@ rtl/rbsi_slab_div.sv @@
module rbsi_slab_div (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   en,
   input  logic                                                   in_valid,
   input  rbsi_pkg::slab_lane_type [rbsi_pkg::LANES-1:0]          in_lane,
   input  rbsi_pkg::ray_type                                      in_ray,
   output logic                                                   out_valid,
   output logic signed [rbsi_pkg::LANES-1:0][rbsi_pkg::T_WIDTH-1:0] out_t,
   output rbsi_pkg::ray_type                                      out_ray
);

   localparam int N  = rbsi_pkg::SLAB_STAGES;
   localparam int RW = rbsi_pkg::SLAB_REM_WIDTH;
   localparam int L  = rbsi_pkg::LANES;
   localparam int QW = rbsi_pkg::VALUE_WIDTH;
   localparam int TW = rbsi_pkg::T_WIDTH;

   logic [N-1:0]                         valid_ff;
   logic [L-1:0][RW-1:0]                 rem_ff  [N];
   logic [L-1:0][QW-1:0]                 quot_ff [N];
   rbsi_pkg::slab_lane_type [L-1:0]      lane_ff [N];
   rbsi_pkg::ray_type                    ray_ff  [N];

   logic                                 fin_valid_ff;
   logic signed [L-1:0][TW-1:0]          fin_t_ff;
   rbsi_pkg::ray_type                    fin_ray_ff;
   logic signed [L-1:0][TW-1:0]          fin_t_in;

   // one quotient bit per stage, six lanes side by side
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                            v_prev;
      logic [L-1:0][RW-1:0]            rem_prev, rem_in;
      logic [L-1:0][QW-1:0]            quot_prev, quot_in;
      logic [RW-1:0]                   trial;
      rbsi_pkg::slab_lane_type [L-1:0] lane_prev;
      rbsi_pkg::ray_type               ray_prev;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign lane_prev = in_lane;
         assign ray_prev  = in_ray;
         assign quot_prev = '0;
         for (genvar l = 0; l < L; l++) begin : g_init
            assign rem_prev[l] = {in_lane[l].num, {rbsi_pkg::FRAC_BITS{1'b0}}};
         end
      end else begin : g_next
         assign v_prev    = valid_ff[s-1];
         assign lane_prev = lane_ff[s-1];
         assign ray_prev  = ray_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
      end

      always_comb begin
         rem_in  = rem_prev;
         quot_in = quot_prev;
         trial   = '0;
         for (int l = 0; l < L; l++) begin
            trial = RW'(lane_prev[l].den) << (N - 1 - s);
            if (rem_prev[l] >= trial) begin
               rem_in[l]             = rem_prev[l] - trial;
               quot_in[l][N - 1 - s] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= quot_in;
            lane_ff[s] <= lane_prev;
            ray_ff[s]  <= ray_prev;
         end
      end
   end

   // clamp to the cap and apply the sign
   always_comb begin
      logic [TW-1:0] mag;
      for (int l = 0; l < L; l++) begin
         mag = lane_ff[N-1][l].sat ? (TW'(1) << QW) : TW'(quot_ff[N-1][l]);
         fin_t_in[l] = lane_ff[N-1][l].neg ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_t_ff   <= fin_t_in;
         fin_ray_ff <= ray_ff[N-1];
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_t     = fin_t_ff;
   assign out_ray   = fin_ray_ff;

endmodule

@@ rtl/ray_box_slab_intersect.sv @@
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    origin, direction, ray length
// rsp       out        rsp_valid/rsp_ready    hit, entry/exit points, t_in/t_out, face
// csr       in         csr_write_enable       csr_index, csr_write_data (box bounds)
//
// one request enters per cycle unless rsp stalls; it passes through the 32-stage square root,
// the 17-stage direction divider and the 33-stage slab divider in series
// reset clears all valid bits and the box registers to zero
// a stall on rsp holds every stage in place; req_ready follows the output register
module ray_box_slab_intersect (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_origin_z,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   input  logic [30:0] req_ray_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [31:0] rsp_entry_x,
   output logic [31:0] rsp_entry_y,
   output logic [31:0] rsp_entry_z,
   output logic [31:0] rsp_exit_x,
   output logic [31:0] rsp_exit_y,
   output logic [31:0] rsp_exit_z,
   output logic [30:0] rsp_enter_param,
   output logic [30:0] rsp_leave_param,
   output logic [1:0]  rsp_face_axis,
   output logic        rsp_normal_negative,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int VW = rbsi_pkg::VALUE_WIDTH;
   localparam int FB = rbsi_pkg::FRAC_BITS;
   localparam int A  = rbsi_pkg::AXES;
   localparam int CW = rbsi_pkg::COMP_WIDTH;
   localparam int TW = rbsi_pkg::T_WIDTH;
   localparam int LW = rbsi_pkg::TLEN_WIDTH;
   localparam int PW = rbsi_pkg::PROD_WIDTH;
   localparam int SW = rbsi_pkg::SUM_WIDTH;

   logic en;

   // box registers
   logic [A-1:0][VW-1:0] box_min_ff, box_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= '0;
         box_max_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (rbsi_pkg::csr_index_type'(csr_index))
            rbsi_pkg::CSR_BOX_MIN_X: box_min_ff[0] <= csr_write_data;
            rbsi_pkg::CSR_BOX_MIN_Y: box_min_ff[1] <= csr_write_data;
            rbsi_pkg::CSR_BOX_MIN_Z: box_min_ff[2] <= csr_write_data;
            rbsi_pkg::CSR_BOX_MAX_X: box_max_ff[0] <= csr_write_data;
            rbsi_pkg::CSR_BOX_MAX_Y: box_max_ff[1] <= csr_write_data;
            rbsi_pkg::CSR_BOX_MAX_Z: box_max_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register is free or being taken
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // input stage: capture ray, direction magnitudes
   logic              p0_valid_ff;
   rbsi_pkg::ray_type p0_ray_ff, p0_ray_in;

   always_comb begin
      logic [A-1:0][VW-1:0] dir;
      dir = {req_dir_z, req_dir_y, req_dir_x};
      p0_ray_in      = '0;
      p0_ray_in.org  = {req_origin_z, req_origin_y, req_origin_x};
      p0_ray_in.tmax = req_ray_length;
      for (int i = 0; i < A; i++) begin
         p0_ray_in.dneg[i] = dir[i][VW-1];
         p0_ray_in.dmag[i] = dir[i][VW-1] ? (~dir[i] + VW'(1)) : dir[i];
      end
   end

   // squares
   logic              p1_valid_ff;
   rbsi_pkg::ray_type p1_ray_ff;
   logic [A-1:0][SW-1:0] p1_sq_ff;

   // sum of squares
   logic              p2_valid_ff;
   rbsi_pkg::ray_type p2_ray_ff;
   logic [SW-1:0]     p2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= req_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ray_ff <= p0_ray_in;
         p1_ray_ff <= p0_ray_ff;
         for (int i = 0; i < A; i++) begin
            p1_sq_ff[i] <= SW'(p0_ray_ff.dmag[i]) * SW'(p0_ray_ff.dmag[i]);
         end
         p2_ray_ff <= p1_ray_ff;
         p2_sum_ff <= p1_sq_ff[0] + p1_sq_ff[1] + p1_sq_ff[2];
      end
   end

   // direction length
   logic                              sq_valid;
   logic [rbsi_pkg::LEN_WIDTH-1:0]    sq_len;
   rbsi_pkg::ray_type                 sq_ray;

   rbsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_sum    (p2_sum_ff),
      .in_ray    (p2_ray_ff),
      .out_valid (sq_valid),
      .out_root  (sq_len),
      .out_ray   (sq_ray)
   );

   // normalized direction components
   logic                 dv_valid;
   logic [A-1:0][CW-1:0] dv_comp;
   rbsi_pkg::ray_type    dv_ray;

   rbsi_dir_div u_dir_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_len    (sq_len),
      .in_ray    (sq_ray),
      .out_valid (dv_valid),
      .out_comp  (dv_comp),
      .out_ray   (dv_ray)
   );

   // slab setup: bound differences, signs, saturation, parallel axes
   function automatic rbsi_pkg::slab_lane_type make_lane(
      input logic [VW:0]   diff,
      input logic [CW-1:0] comp,
      input logic          dneg
   );
      rbsi_pkg::slab_lane_type lane;
      logic [VW:0]             neg_diff;
      neg_diff  = ~diff + (VW+1)'(1);
      lane.num  = diff[VW] ? neg_diff[VW-1:0] : diff[VW-1:0];
      lane.den  = comp;
      lane.sat  = {1'b0, lane.num} >= {comp, {FB{1'b0}}};
      lane.neg  = diff[VW] ^ dneg;
      return lane;
   endfunction

   logic                                               su_valid_ff;
   rbsi_pkg::slab_lane_type [rbsi_pkg::LANES-1:0]      su_lane_ff, su_lane_in;
   rbsi_pkg::ray_type                                  su_ray_ff, su_ray_in;

   always_comb begin
      logic signed [VW-1:0] o, lo, hi;
      logic [VW:0]          d_lo, d_hi;
      logic [A-1:0]         fail;
      su_ray_in      = dv_ray;
      su_ray_in.comp = dv_comp;
      for (int i = 0; i < A; i++) begin
         o    = $signed(dv_ray.org[i]);
         lo   = $signed(box_min_ff[i]);
         hi   = $signed(box_max_ff[i]);
         d_lo = {lo[VW-1], lo} - {o[VW-1], o};
         d_hi = {hi[VW-1], hi} - {o[VW-1], o};
         su_lane_in[2*i]   = make_lane(d_lo, dv_comp[i], dv_ray.dneg[i]);
         su_lane_in[2*i+1] = make_lane(d_hi, dv_comp[i], dv_ray.dneg[i]);
         su_ray_in.par[i]  = (dv_comp[i] == '0);
         fail[i]           = su_ray_in.par[i] && (o < lo || o > hi);
      end
      su_ray_in.par_fail = |fail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_valid_ff <= 1'b0;
      end else if (en) begin
         su_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         su_lane_ff <= su_lane_in;
         su_ray_ff  <= su_ray_in;
      end
   end

   // slab parameters
   logic                                                sl_valid;
   logic signed [rbsi_pkg::LANES-1:0][TW-1:0]           sl_t;
   rbsi_pkg::ray_type                                   sl_ray;

   rbsi_slab_div u_slab_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (su_valid_ff),
      .in_lane   (su_lane_ff),
      .in_ray    (su_ray_ff),
      .out_valid (sl_valid),
      .out_t     (sl_t),
      .out_ray   (sl_ray)
   );

   // order near and far per axis
   logic                         sw_valid_ff;
   logic signed [A-1:0][TW-1:0]  sw_near_ff, sw_far_ff;
   rbsi_pkg::ray_type            sw_ray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_valid_ff <= 1'b0;
      end else if (en) begin
         sw_valid_ff <= sl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sw_ray_ff <= sl_ray;
         for (int i = 0; i < A; i++) begin
            if ($signed(sl_t[2*i]) > $signed(sl_t[2*i+1])) begin
               sw_near_ff[i] <= sl_t[2*i+1];
               sw_far_ff[i]  <= sl_t[2*i];
            end else begin
               sw_near_ff[i] <= sl_t[2*i];
               sw_far_ff[i]  <= sl_t[2*i+1];
            end
         end
      end
   end

   // combine axes: latest entry, earliest exit
   logic                 cb_valid_ff;
   logic signed [TW-1:0] cb_tin_ff, cb_tout_ff, cb_tin_in, cb_tout_in;
   logic [1:0]           cb_axis_ff, cb_axis_in;
   rbsi_pkg::ray_type    cb_ray_ff;

   always_comb begin
      cb_tin_in  = '0;
      cb_tout_in = TW'(sw_ray_ff.tmax);
      cb_axis_in = rbsi_pkg::AXIS_INSIDE;
      for (int i = 0; i < A; i++) begin
         if (!sw_ray_ff.par[i]) begin
            if ($signed(sw_near_ff[i]) > cb_tin_in) begin
               cb_tin_in  = sw_near_ff[i];
               cb_axis_in = 2'(i);
            end
            if ($signed(sw_far_ff[i]) < cb_tout_in) begin
               cb_tout_in = sw_far_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_valid_ff <= 1'b0;
      end else if (en) begin
         cb_valid_ff <= sw_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cb_tin_ff  <= cb_tin_in;
         cb_tout_ff <= cb_tout_in;
         cb_axis_ff <= cb_axis_in;
         cb_ray_ff  <= sw_ray_ff;
      end
   end

   // hit decision and point offsets
   logic                 pr_valid_ff;
   logic                 pr_hit_ff;
   logic                 pr_nneg_ff, pr_nneg_in;
   logic [1:0]           pr_axis_ff;
   logic [LW-1:0]        pr_tin_ff, pr_tout_ff;
   logic [A-1:0][PW-1:0] pr_pin_ff, pr_pout_ff;
   rbsi_pkg::ray_type    pr_ray_ff;

   always_comb begin
      case (cb_axis_ff)
         2'd0:    pr_nneg_in = !cb_ray_ff.dneg[0];
         2'd1:    pr_nneg_in = !cb_ray_ff.dneg[1];
         2'd2:    pr_nneg_in = !cb_ray_ff.dneg[2];
         default: pr_nneg_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (en) begin
         pr_valid_ff <= cb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_hit_ff  <= !cb_ray_ff.par_fail && !(cb_tin_ff > cb_tout_ff);
         pr_nneg_ff <= pr_nneg_in;
         pr_axis_ff <= cb_axis_ff;
         pr_tin_ff  <= cb_tin_ff[LW-1:0];
         pr_tout_ff <= cb_tout_ff[LW-1:0];
         pr_ray_ff  <= cb_ray_ff;
         for (int i = 0; i < A; i++) begin
            pr_pin_ff[i]  <= PW'(cb_tin_ff[LW-1:0]) * PW'(cb_ray_ff.comp[i]);
            pr_pout_ff[i] <= PW'(cb_tout_ff[LW-1:0]) * PW'(cb_ray_ff.comp[i]);
         end
      end
   end

   // origin plus offset, saturated
   function automatic logic [VW-1:0] walk(
      input logic [VW-1:0] o,
      input logic [PW-1:0] prod,
      input logic          dneg
   );
      logic [VW-1:0]        m;
      logic signed [VW+1:0] p;
      m = prod[PW-1:FB];
      if (dneg) begin
         p = $signed({{2{o[VW-1]}}, o}) - $signed({2'b00, m});
      end else begin
         p = $signed({{2{o[VW-1]}}, o}) + $signed({2'b00, m});
      end
      if (p > $signed({3'b000, {(VW-1){1'b1}}})) begin
         return {1'b0, {(VW-1){1'b1}}};
      end else if (p < $signed({3'b111, {(VW-1){1'b0}}})) begin
         return {1'b1, {(VW-1){1'b0}}};
      end
      return p[VW-1:0];
   endfunction

   logic                 rsp_hit_ff;
   logic [A-1:0][VW-1:0] rsp_entry_ff, rsp_exit_ff;
   logic [LW-1:0]        rsp_tin_ff, rsp_tout_ff;
   logic [1:0]           rsp_axis_ff;
   logic                 rsp_nneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= pr_valid_ff;
      end
   end

   // output register; a miss clears every field
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff  <= pr_hit_ff;
         rsp_tin_ff  <= pr_hit_ff ? pr_tin_ff : '0;
         rsp_tout_ff <= pr_hit_ff ? pr_tout_ff : '0;
         rsp_axis_ff <= pr_hit_ff ? pr_axis_ff : 2'd0;
         rsp_nneg_ff <= pr_hit_ff && pr_nneg_ff;
         for (int i = 0; i < A; i++) begin
            rsp_entry_ff[i] <= pr_hit_ff ?
               walk(pr_ray_ff.org[i], pr_pin_ff[i], pr_ray_ff.dneg[i]) : '0;
            rsp_exit_ff[i]  <= pr_hit_ff ?
               walk(pr_ray_ff.org[i], pr_pout_ff[i], pr_ray_ff.dneg[i]) : '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_entry_x         = rsp_entry_ff[0];
   assign rsp_entry_y         = rsp_entry_ff[1];
   assign rsp_entry_z         = rsp_entry_ff[2];
   assign rsp_exit_x          = rsp_exit_ff[0];
   assign rsp_exit_y          = rsp_exit_ff[1];
   assign rsp_exit_z          = rsp_exit_ff[2];
   assign rsp_enter_param     = rsp_tin_ff;
   assign rsp_leave_param     = rsp_tout_ff;
   assign rsp_face_axis       = rsp_axis_ff;
   assign rsp_normal_negative = rsp_nneg_ff;

endmodule
